// ===== rtl/core/pidc_pkg.sv =====
// package for the clamped pid controller: widths, register map, config and stage types
// no dependencies; imported by every module of the block

package pidc_pkg;

	localparam int ENCODER_COUNTS = 8192;

	localparam int DATA_W  = 16;
	localparam int GAIN_W  = 24;
	localparam int LIM_W   = 15;
	localparam int FRAC_W  = 16;
	localparam int ERR_W   = DATA_W + 1;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int P_W     = GAIN_W + ERR_W;
	localparam int D_W     = GAIN_W + DIFF_W;
	localparam int ACC_W   = LIM_W + FRAC_W + 1;
	localparam int ISUM_W  = P_W + 1;
	localparam int PD_W    = D_W + 1;
	localparam int SUM_W   = PD_W + 1;
	localparam int SHIFT_W = SUM_W - FRAC_W;

	localparam logic signed [ERR_W:0] WRAP_HALF = (ERR_W + 1)'(ENCODER_COUNTS / 2 - 1);
	localparam logic signed [ERR_W:0] WRAP_SPAN = (ERR_W + 1)'(ENCODER_COUNTS);

	localparam int NUM_REGS  = 6;
	localparam int APB_W     = 32;
	localparam int PADDR_W   = $clog2(NUM_REGS * 4);
	localparam int REG_IDX_W = PADDR_W - 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PROP_GAIN   = REG_IDX_W'(0),
		REG_INTEG_GAIN  = REG_IDX_W'(1),
		REG_DERIV_GAIN  = REG_IDX_W'(2),
		REG_INTEG_LIMIT = REG_IDX_W'(3),
		REG_DRIVE_LIMIT = REG_IDX_W'(4),
		REG_ANGLE_MODE  = REG_IDX_W'(5)
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [LIM_W-1:0]  integ_limit;
		logic [LIM_W-1:0]  drive_limit;
		logic              angle_wrap_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]  err;
		logic signed [DIFF_W-1:0] diff;
	} err_item_t;

	typedef struct packed {
		logic signed [P_W-1:0] p;
		logic signed [P_W-1:0] ip;
		logic signed [D_W-1:0] d;
	} prod_item_t;

endpackage

// ===== rtl/core/pidc_cfg.sv =====
// apb register file holding gains, limits and the angle wrap mode
// depends on pidc_pkg

module pidc_cfg import pidc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PROP_GAIN:   cfg_q.prop_gain       <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain      <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain      <= pwdata[GAIN_W-1:0];
				REG_INTEG_LIMIT: cfg_q.integ_limit     <= pwdata[LIM_W-1:0];
				REG_DRIVE_LIMIT: cfg_q.drive_limit     <= pwdata[LIM_W-1:0];
				REG_ANGLE_MODE:  cfg_q.angle_wrap_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PROP_GAIN:   prdata = APB_W'(cfg_q.prop_gain);
			REG_INTEG_GAIN:  prdata = APB_W'(cfg_q.integ_gain);
			REG_DERIV_GAIN:  prdata = APB_W'(cfg_q.deriv_gain);
			REG_INTEG_LIMIT: prdata = APB_W'(cfg_q.integ_limit);
			REG_DRIVE_LIMIT: prdata = APB_W'(cfg_q.drive_limit);
			REG_ANGLE_MODE:  prdata = APB_W'(cfg_q.angle_wrap_mode);
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/pidc_err.sv =====
// input register and error stage: difference, encoder wrap, error delta, last error state
// depends on pidc_pkg

module pidc_err import pidc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] setpoint,
	input  logic signed [DATA_W-1:0] measured,
	input  logic                     angle_wrap_mode,
	output logic                     item_valid,
	input  logic                     item_ready,
	output err_item_t                item
);

	logic                     v_s1;
	logic                     v_s2;
	logic signed [DATA_W-1:0] sp_s1;
	logic signed [DATA_W-1:0] fb_s1;
	err_item_t                item_s2;
	logic signed [ERR_W-1:0]  last_error_q;

	logic signed [ERR_W:0]    raw;
	logic signed [ERR_W:0]    sub_wrap;
	logic signed [ERR_W:0]    add_wrap;
	logic signed [ERR_W-1:0]  err;
	logic signed [DIFF_W-1:0] diff;
	logic                     rdy_s2;
	logic                     take_s2;

	assign rdy_s2   = !v_s2 || item_ready;
	assign in_ready = !v_s1 || rdy_s2;
	assign take_s2  = v_s1 && rdy_s2;

	// wrap tests run in order: subtract first, then add
	assign raw      = (ERR_W + 1)'(sp_s1) - (ERR_W + 1)'(fb_s1);
	assign sub_wrap = (angle_wrap_mode && raw > WRAP_HALF) ? raw - WRAP_SPAN : raw;
	assign add_wrap = (angle_wrap_mode && sub_wrap < -WRAP_HALF) ? sub_wrap + WRAP_SPAN
		: sub_wrap;
	assign err      = ERR_W'(add_wrap);
	assign diff     = DIFF_W'(err) - DIFF_W'(last_error_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			last_error_q <= '0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (take_s2) last_error_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sp_s1 <= setpoint;
			fb_s1 <= measured;
		end
		if (take_s2) begin
			item_s2.err  <= err;
			item_s2.diff <= diff;
		end
	end

	assign item_valid = v_s2;
	assign item       = item_s2;

endmodule

// ===== rtl/core/pidc_mul.sv =====
// product stage: proportional, integral increment and derivative products
// depends on pidc_pkg

module pidc_mul import pidc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              item_valid,
	output logic              item_ready,
	input  err_item_t         item,
	output logic              prod_valid,
	input  logic              prod_ready,
	output prod_item_t        prod
);

	logic                  v_s3;
	prod_item_t            prod_s3;
	logic signed [P_W-1:0] p;
	logic signed [P_W-1:0] ip;
	logic signed [D_W-1:0] d;
	logic                  take_s3;

	assign item_ready = !v_s3 || prod_ready;
	assign take_s3    = item_valid && item_ready;

	assign p  = signed'(P_W'(cfg.prop_gain)) * P_W'(item.err);
	assign ip = signed'(P_W'(cfg.integ_gain)) * P_W'(item.err);
	assign d  = signed'(D_W'(cfg.deriv_gain)) * D_W'(item.diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (item_ready) begin
			v_s3 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3) begin
			prod_s3.p  <= p;
			prod_s3.ip <= ip;
			prod_s3.d  <= d;
		end
	end

	assign prod_valid = v_s3;
	assign prod       = prod_s3;

endmodule

// ===== rtl/core/pidc_out.sv =====
// integral accumulator with clamp, term sum, shift to whole units, drive clamp, output register
// depends on pidc_pkg

module pidc_out import pidc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     prod_valid,
	output logic                     prod_ready,
	input  prod_item_t               prod,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] drive
);

	logic                      v_s4;
	logic signed [PD_W-1:0]    pd_s4;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  drive_q;

	logic signed [ISUM_W-1:0]  isum;
	logic signed [ISUM_W-1:0]  ilim;
	logic signed [ACC_W-1:0]   acc_next;
	logic signed [PD_W-1:0]    pd;
	logic signed [SUM_W-1:0]   sum;
	logic signed [SHIFT_W-1:0] whole;
	logic signed [SHIFT_W-1:0] dlim;
	logic signed [DATA_W-1:0]  drive_next;
	logic                      rdy_o;
	logic                      take_s4;
	logic                      take_o;

	assign rdy_o      = !out_valid_q || out_ready;
	assign prod_ready = !v_s4 || rdy_o;
	assign take_s4    = prod_valid && prod_ready;
	assign take_o     = v_s4 && rdy_o;

	assign isum = ISUM_W'(acc_q) + ISUM_W'(prod.ip);
	assign ilim = signed'(ISUM_W'({cfg.integ_limit, {FRAC_W{1'b0}}}));

	always_comb begin
		priority if (isum >= ilim) begin
			acc_next = ACC_W'(ilim);
		end else if (isum <= -ilim) begin
			acc_next = ACC_W'(-ilim);
		end else begin
			acc_next = ACC_W'(isum);
		end
	end

	assign pd = PD_W'(prod.p) + PD_W'(prod.d);

	// acc_q already holds this item's integral while it sits in s4
	assign sum   = SUM_W'(pd_s4) + SUM_W'(acc_q);
	assign whole = SHIFT_W'(sum >>> FRAC_W);
	assign dlim  = signed'(SHIFT_W'(cfg.drive_limit));

	always_comb begin
		priority if (whole >= dlim) begin
			drive_next = DATA_W'(dlim);
		end else if (whole <= -dlim) begin
			drive_next = DATA_W'(-dlim);
		end else begin
			drive_next = DATA_W'(whole);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			if (prod_ready) v_s4 <= prod_valid;
			if (rdy_o) out_valid_q <= v_s4;
			if (take_s4) acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s4) pd_s4 <= pd;
		if (take_o) drive_q <= drive_next;
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

// ===== rtl/core/pid_controller_clamped.sv =====
// top level of the clamped positional pid controller
// depends on pidc_pkg, pidc_cfg, pidc_err, pidc_mul, pidc_out
//
// usage:
// - gains, limits and the angle wrap mode are written through the apb port
//   (register i at byte address 4*i); pready is always high, reads return
//   the register value
// - one item per sample: setpoint and measured on in_valid/in_ready, one
//   drive value per item on out_valid/out_ready, in the same order
// - the drive for an item passes through the input register, error stage,
//   product stage, integral stage and output register, in that order
// - throughput: one item per cycle while out_ready is high; the integral and
//   last error updates each close in a single stage, so consecutive items need no spacing
// - when the receiver stalls, each stage keeps taking items until it is full,
//   so up to five items are absorbed before in_ready drops
// - reset clears the config registers, the valid flags, the last error and
//   the integral to zero and empties the pipeline; data registers are not reset

module pid_controller_clamped import pidc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [APB_W-1:0]         pwdata,
	output logic [APB_W-1:0]         prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] setpoint,
	input  logic signed [DATA_W-1:0] measured,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] drive
);

	cfg_t       cfg;
	logic       err_valid;
	logic       err_ready;
	err_item_t  err_item;
	logic       prod_valid;
	logic       prod_ready;
	prod_item_t prod_item;

	pidc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pidc_err u_err (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.setpoint        (setpoint),
		.measured        (measured),
		.angle_wrap_mode (cfg.angle_wrap_mode),
		.item_valid      (err_valid),
		.item_ready      (err_ready),
		.item            (err_item)
	);

	pidc_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (err_valid),
		.item_ready (err_ready),
		.item       (err_item),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod_item)
	);

	pidc_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready),
		.prod       (prod_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.drive      (drive)
	);

	// an empty output register lets every stage move, so input is open
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with empty output register");

	// the drive clamp never yields the most negative code
	a_drive_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive != signed'(DATA_W'(1) << (DATA_W - 1)))
		else $error("drive outside clamp range");

	// an item leaving the error stage with a full downstream must not be dropped
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		err_valid && !err_ready |=> err_valid)
		else $error("error stage item lost while stalled");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for pid_controller_clamped: directed and random samples over apb configs
// depends on pidc_pkg and the pid_controller_clamped rtl; carries its own drive predictor

module testbench import pidc_pkg::*;;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam longint WRAP_EDGE = ENCODER_COUNTS / 2 - 1;

	class drive_scoreboard;
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		logic [LIM_W-1:0] integ_lim;
		logic [LIM_W-1:0] drive_lim;
		logic wrap_en;
		logic signed [ERR_W-1:0] prev_err;
		logic signed [47:0] integ;
		logic signed [DATA_W-1:0] expected_drive[$];
		int failures;

		function void reset_state();
			kp = '0;
			ki = '0;
			kd = '0;
			integ_lim = '0;
			drive_lim = '0;
			wrap_en = 1'b0;
			prev_err = '0;
			integ = '0;
			failures = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [APB_W-1:0] v);
			case (idx)
				REG_PROP_GAIN: kp = v[GAIN_W-1:0];
				REG_INTEG_GAIN: ki = v[GAIN_W-1:0];
				REG_DERIV_GAIN: kd = v[GAIN_W-1:0];
				REG_INTEG_LIMIT: integ_lim = v[LIM_W-1:0];
				REG_DRIVE_LIMIT: drive_lim = v[LIM_W-1:0];
				REG_ANGLE_MODE: wrap_en = v[0];
				default: ;
			endcase
		endfunction

		function longint bound(longint x, longint lim);
			if (x >= lim)
				return lim;
			if (x <= -lim)
				return -lim;
			return x;
		endfunction

		function void note_sample(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] meas);
			longint err;
			longint acc;
			longint sum;
			longint y;
			err = longint'(sp) - longint'(meas);
			if (wrap_en) begin
				if (err > WRAP_EDGE)
					err -= ENCODER_COUNTS;
				if (err < -WRAP_EDGE)
					err += ENCODER_COUNTS;
			end
			acc = longint'(integ) + longint'(ki) * err;
			acc = bound(acc, longint'(integ_lim) * 65536);
			integ = acc[47:0];
			sum = longint'(kp) * err + acc + longint'(kd) * (err - longint'(prev_err));
			prev_err = err[ERR_W-1:0];
			y = bound(sum >>> FRAC_W, longint'(drive_lim));
			expected_drive.push_back(y[DATA_W-1:0]);
		endfunction

		function void check_drive(logic signed [DATA_W-1:0] got);
			logic signed [DATA_W-1:0] want;
			if (expected_drive.size() == 0) begin
				if (failures < 10)
					$display("unexpected drive item %0d at %0t", got, $realtime);
				failures++;
				return;
			end
			want = expected_drive.pop_front();
			if (got !== want) begin
				if (failures < 10)
					$display("drive mismatch at %0t: expected %0d, got %0d", $realtime, want, got);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_W-1:0] pwdata;
	logic [APB_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_ready;
	logic signed [DATA_W-1:0] setpoint;
	logic signed [DATA_W-1:0] measured;
	logic out_valid;
	logic out_ready;
	logic signed [DATA_W-1:0] drive;

	drive_scoreboard sb;
	bit quiet = 1'b0;
	int stall_cycles = 0;

	pid_controller_clamped uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.setpoint(setpoint),
		.measured(measured),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive(drive)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 25)
			return '1;
		if (r < 85)
			return GAIN_W'($urandom_range(0, 24'h02_0000));
		return GAIN_W'($urandom());
	endfunction

	function automatic logic [LIM_W-1:0] pick_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return '0;
		if (r < 30)
			return '1;
		return LIM_W'($urandom_range(1, 32767));
	endfunction

	// apb write: setup edge, then access edge where the register takes the value
	task automatic write_reg(reg_idx_t idx, logic [APB_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic apb_idle();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] meas);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		setpoint <= sp;
		measured <= meas;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic make_sample(output logic signed [DATA_W-1:0] sp,
		output logic signed [DATA_W-1:0] meas);
		int r;
		int delta;
		r = $urandom_range(0, 99);
		sp = DATA_W'($urandom());
		if (r < 60) begin
			delta = $urandom_range(0, 400);
			meas = sp - DATA_W'(delta - 200);
		end else if (r < 80) begin
			sp = DATA_W'($urandom_range(0, ENCODER_COUNTS - 1));
			meas = DATA_W'($urandom_range(0, ENCODER_COUNTS - 1));
		end else begin
			meas = DATA_W'($urandom());
		end
	endtask

	// block is idle once every drive has come back; leave margin for the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_drive.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_sample(setpoint, measured);
			if (out_valid && out_ready)
				sb.check_drive(drive);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		logic signed [DATA_W-1:0] sp;
		logic signed [DATA_W-1:0] meas;
		sb = new;
		sb.reset_state();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		setpoint <= '0;
		measured <= '0;
		out_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain difference, field extremes
		write_reg(REG_PROP_GAIN, 32'h0001_0000);
		write_reg(REG_INTEG_GAIN, 32'h0000_4000);
		write_reg(REG_DERIV_GAIN, 32'h0000_8000);
		write_reg(REG_INTEG_LIMIT, 32'h0000_7FFF);
		write_reg(REG_DRIVE_LIMIT, 32'h0000_7FFF);
		write_reg(REG_ANGLE_MODE, 32'h0);
		apb_idle();
		send(16'sh7FFF, 16'sh8000);
		send(16'sh8000, 16'sh7FFF);
		send(16'sh0000, 16'sh0000);
		send(16'sh7FFF, 16'sh7FFF);
		send(16'sh8000, 16'sh8000);
		send(-16'sd1, 16'sd0);
		send(16'sd1, -16'sd1);

		// angle wrap boundaries and wide errors, state kept across the mode change
		settle();
		write_reg(REG_ANGLE_MODE, 32'h1);
		apb_idle();
		send(16'sd4095, 16'sd0);
		send(16'sd4096, 16'sd0);
		send(16'sd0, 16'sd4095);
		send(16'sd0, 16'sd4096);
		send(16'sd8191, 16'sd0);
		send(-16'sd8192, 16'sd0);
		send(16'sh7FFF, 16'sh8000);
		send(16'sh8000, 16'sh7FFF);
		send(16'sd12288, 16'sd0);
		send(-16'sd100, 16'sd12189);

		// zero limits with full gains
		settle();
		write_reg(REG_PROP_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_INTEG_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_DERIV_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_INTEG_LIMIT, 32'hFFFF_8000);
		write_reg(REG_DRIVE_LIMIT, 32'h0);
		write_reg(REG_ANGLE_MODE, 32'h0);
		apb_idle();
		send(16'sd1000, -16'sd1000);
		send(16'sh8000, 16'sh7FFF);
		send(16'sd5, 16'sd5);

		for (int ph = 0; ph < 13; ph++) begin
			settle();
			quiet = (ph % 4 == 1);
			write_reg(REG_PROP_GAIN, {8'($urandom()), pick_gain()});
			write_reg(REG_INTEG_GAIN, {8'($urandom()), pick_gain()});
			write_reg(REG_DERIV_GAIN, {8'($urandom()), pick_gain()});
			write_reg(REG_INTEG_LIMIT, {17'($urandom()), pick_limit()});
			write_reg(REG_DRIVE_LIMIT, {17'($urandom()), pick_limit()});
			write_reg(REG_ANGLE_MODE, $urandom());
			apb_idle();
			for (int n = 0; n < 106; n++) begin
				make_sample(sp, meas);
				send(sp, meas);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_drive.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.expected_drive.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
